>>> sv/hpid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpid_pkg
// Shared constants and register map of the heading PID controller.
// ----------------------------------------------------------------------------
package hpid_pkg;

  // fixed point formats
  localparam int AngleFracBits = 4;
  localparam int GainFracBits  = 8;
  localparam int FullFracBits  = AngleFracBits + GainFracBits;

  // integral window in whole degrees
  localparam int WindowDeg = 10;

  // integral saturation
  localparam int IntegW = 24;

  // apb
  localparam int ApbAddrW = 5;
  localparam int ApbDataW = 32;

  // register indexes
  typedef enum logic [2:0] {
    REG_TARGET_ANGLE = 3'd0,
    REG_GAIN_P       = 3'd1,
    REG_GAIN_I       = 3'd2,
    REG_GAIN_D       = 3'd3,
    REG_DRIVE_LIMIT  = 3'd4,
    REG_SETTLE_BAND  = 3'd5,
    REG_SETTLE_TICKS = 3'd6,
    REG_STALL_TICKS  = 3'd7
  } hpid_reg_e;

  // reset values
  localparam logic [15:0] TargetAngleRst = 16'd0;
  localparam logic [11:0] GainPRst       = 12'd410;
  localparam logic [11:0] GainIRst       = 12'd205;
  localparam logic [11:0] GainDRst       = 12'd115;
  localparam logic [6:0]  DriveLimitRst  = 7'd127;
  localparam logic [11:0] SettleBandRst  = 12'd32;
  localparam logic [7:0]  SettleTicksRst = 8'd5;
  localparam logic [7:0]  StallTicksRst  = 8'd60;

endpackage : hpid_pkg
`default_nettype wire

>>> sv/heading_pid_with_settle_detect_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// heading_pid_with_settle_detect_top
// Heading PID controller with windowed leaky integral and settle/stall detect.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one measured heading per control tick (tdata[15:0]).
//   m_axis returns one result per heading: drive in tdata[7:0], absolute
//   error in whole degrees in tdata[19:8], done flag in tuser[0].
//   The apb port holds the eight control registers at byte address 4*i;
//   write them only while no heading is in flight.
//   Each heading passes the input register, then the result register.
//   Throughput is one item per cycle while the receiver does not stall:
//   the error, the three gain multiplies, the integral update and the
//   clamp all sit between the input register and the result register, and
//   the controller state is registered together with the result.
//   When the receiver stalls, the result register holds and the input
//   register takes one more item, then tready drops until the output moves.
//   Reset clears the controller state and loads the default gains.
// ----------------------------------------------------------------------------
module heading_pid_with_settle_detect_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [15:0]                   s_axis_tdata,  // [15:0] heading
  // output stream
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [23:0]                   m_axis_tdata,  // [7:0] drive, [19:8] error_whole
  output      logic [0:0]                    m_axis_tuser,  // [0] done_res
  // apb configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hpid_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [hpid_pkg::ApbDataW-1:0] pwdata,
  output      logic [hpid_pkg::ApbDataW-1:0] prdata,
  output      logic                          pready
);
  import hpid_pkg::*;

  localparam int ProdPW = 30;
  localparam int ProdDW = 31;
  localparam int ProdIW = 38;
  localparam int SumW   = 33 + AngleFracBits;

  localparam logic signed [ProdPW-1:0] PBias = ProdPW'((64'd1 << FullFracBits) - 64'd1);
  localparam logic signed [ProdDW-1:0] DBias = ProdDW'((64'd1 << FullFracBits) - 64'd1);
  localparam logic signed [ProdIW-1:0] IBias = ProdIW'((64'd1 << GainFracBits) - 64'd1);
  localparam logic signed [SumW-1:0]   SBias = SumW'((64'd1 << AngleFracBits) - 64'd1);
  localparam logic [16:0] WindowLim = 17'(WindowDeg << AngleFracBits);
  localparam logic signed [ProdIW-1:0] IntegMax = ProdIW'((64'd1 << (IntegW - 1)) - 64'd1);
  localparam logic signed [ProdIW-1:0] IntegMin = -ProdIW'(64'd1 << (IntegW - 1));

  // configuration registers
  logic [15:0] target_angle_q;
  logic [11:0] gain_p_q, gain_i_q, gain_d_q, settle_band_q;
  logic [6:0]  drive_limit_q;
  logic [7:0]  settle_ticks_q, stall_ticks_q;

  logic      cfg_wr;
  hpid_reg_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = hpid_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_angle_q <= TargetAngleRst;
      gain_p_q       <= GainPRst;
      gain_i_q       <= GainIRst;
      gain_d_q       <= GainDRst;
      drive_limit_q  <= DriveLimitRst;
      settle_band_q  <= SettleBandRst;
      settle_ticks_q <= SettleTicksRst;
      stall_ticks_q  <= StallTicksRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TARGET_ANGLE: target_angle_q <= pwdata[15:0];
        REG_GAIN_P:       gain_p_q       <= pwdata[11:0];
        REG_GAIN_I:       gain_i_q       <= pwdata[11:0];
        REG_GAIN_D:       gain_d_q       <= pwdata[11:0];
        REG_DRIVE_LIMIT:  drive_limit_q  <= pwdata[6:0];
        REG_SETTLE_BAND:  settle_band_q  <= pwdata[11:0];
        REG_SETTLE_TICKS: settle_ticks_q <= pwdata[7:0];
        REG_STALL_TICKS:  stall_ticks_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_TARGET_ANGLE: prdata[15:0] = target_angle_q;
      REG_GAIN_P:       prdata[11:0] = gain_p_q;
      REG_GAIN_I:       prdata[11:0] = gain_i_q;
      REG_GAIN_D:       prdata[11:0] = gain_d_q;
      REG_DRIVE_LIMIT:  prdata[6:0]  = drive_limit_q;
      REG_SETTLE_BAND:  prdata[11:0] = settle_band_q;
      REG_SETTLE_TICKS: prdata[7:0]  = settle_ticks_q;
      REG_STALL_TICKS:  prdata[7:0]  = stall_ticks_q;
      default: ;
    endcase
  end

  // input register and handshake
  logic        in_valid_q;
  logic [15:0] heading_q;
  logic        advance;

  assign advance       = in_valid_q & (~m_axis_tvalid | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      heading_q <= s_axis_tdata;
    end
  end

  // controller state
  logic signed [IntegW-1:0] integ_q, integ_d;
  logic signed [16:0]       prev_err_q;
  logic [11:0]              prev_whole_q, whole;
  logic [7:0]               same_cnt_q, same_cnt_d, small_cnt_q, small_cnt_d;

  // datapath
  logic signed [16:0]       err, prev_abs_s;
  logic [15:0]              err_abs, prev_abs, whole_raw;
  logic signed [ProdPW-1:0] p_prod, p_term;
  logic signed [17:0]       err_diff;
  logic signed [ProdDW-1:0] d_prod, d_term;
  logic signed [24:0]       integ_in;
  logic signed [ProdIW-1:0] i_prod, i_term;
  logic signed [31:0]       pd;
  logic signed [SumW-1:0]   pd_ext, sum_pre, sum_trunc, sum_clamp, lim_s;
  logic                     done;

  always_comb begin
    err        = $signed({target_angle_q[15], target_angle_q}) -
                 $signed({heading_q[15], heading_q});
    err_abs    = err[16] ? 16'(-err) : err[15:0];
    prev_abs_s = prev_err_q[16] ? -prev_err_q : prev_err_q;
    prev_abs   = prev_abs_s[15:0];

    // proportional, rounded toward zero
    p_prod = err * $signed({1'b0, gain_p_q});
    p_term = ((p_prod < 0) ? p_prod + PBias : p_prod) >>> FullFracBits;

    // derivative on the signed previous error
    err_diff = $signed({err[16], err}) - $signed({prev_err_q[16], prev_err_q});
    d_prod   = err_diff * $signed({1'b0, gain_d_q});
    d_term   = ((d_prod < 0) ? d_prod + DBias : d_prod) >>> FullFracBits;

    // leaky windowed integral
    integ_in = $signed({integ_q[IntegW-1], integ_q}) + $signed({{8{err[16]}}, err});
    i_prod   = integ_in * $signed({1'b0, gain_i_q});
    i_term   = ((i_prod < 0) ? i_prod + IBias : i_prod) >>> GainFracBits;
    if ({1'b0, err_abs} >= WindowLim) begin
      integ_d = '0;
    end else if (i_term > IntegMax) begin
      integ_d = IntegMax[IntegW-1:0];
    end else if (i_term < IntegMin) begin
      integ_d = IntegMin[IntegW-1:0];
    end else begin
      integ_d = i_term[IntegW-1:0];
    end

    // sum of terms, clamp follows the sign of the sum
    pd        = 32'(p_term) + 32'(d_term);
    pd_ext    = SumW'(pd);
    sum_pre   = (pd_ext <<< AngleFracBits) + SumW'(integ_d);
    sum_trunc = ((sum_pre < 0) ? sum_pre + SBias : sum_pre) >>> AngleFracBits;
    lim_s     = $signed({{(SumW - 7){1'b0}}, drive_limit_q});
    if (sum_trunc > lim_s) begin
      sum_clamp = lim_s;
    end else if (sum_trunc < -lim_s) begin
      sum_clamp = -lim_s;
    end else begin
      sum_clamp = sum_trunc;
    end

    // whole-degree error, saturated
    whole_raw = err_abs >> AngleFracBits;
    whole     = (whole_raw > 16'd4095) ? 12'd4095 : whole_raw[11:0];

    // settle and stall counters
    if (whole == prev_whole_q) begin
      small_cnt_d = small_cnt_q;
      if ((prev_abs <= {4'd0, settle_band_q}) && (err_abs <= {4'd0, settle_band_q}) &&
          !(&small_cnt_q)) begin
        small_cnt_d = small_cnt_q + 8'd1;
      end
      same_cnt_d = (&same_cnt_q) ? same_cnt_q : same_cnt_q + 8'd1;
    end else begin
      small_cnt_d = '0;
      same_cnt_d  = '0;
    end
    done = (small_cnt_d >= settle_ticks_q) || (same_cnt_d >= stall_ticks_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q      <= '0;
      prev_err_q   <= '0;
      prev_whole_q <= '0;
      same_cnt_q   <= '0;
      small_cnt_q  <= '0;
    end else if (advance) begin
      integ_q      <= integ_d;
      prev_err_q   <= err;
      prev_whole_q <= whole;
      same_cnt_q   <= same_cnt_d;
      small_cnt_q  <= small_cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      m_axis_tdata <= {4'd0, whole, (done ? 8'd0 : sum_clamp[7:0])};
      m_axis_tuser <= done;
    end
  end

endmodule : heading_pid_with_settle_detect_top
`default_nettype wire
